FILE: rtl/eib_pkg.sv
// ---------------------------------------------------------------------------
// eib_pkg
// shared widths, register indexes, types and state codes of the
// envelope intensity bound block
// ---------------------------------------------------------------------------
package eib_pkg;

    localparam int MAX_PEAKS      = 64;
    localparam int INTENSITY_BITS = 32;
    localparam int ADDR_W         = $clog2(MAX_PEAKS);
    localparam int CNT_W          = $clog2(MAX_PEAKS + 1);
    localparam int SUM_W          = INTENSITY_BITS + ADDR_W;
    localparam int BOUND_W        = 17;
    localparam int BOUND_SHIFT    = 16;
    localparam int PROD_W         = BOUND_W + SUM_W;
    localparam int CLAMP_W        = 7;
    localparam int REF_W          = 6;
    localparam int CFG_ADDR_W     = 4;
    localparam int CFG_DATA_W     = 32;

    localparam logic [BOUND_W-1:0]        BOUND_RESET   = BOUND_W'(55706);
    localparam logic [INTENSITY_BITS-1:0] MIN_RESET     = '0;
    localparam logic [CLAMP_W-1:0]        MAX_BACK_RESET = CLAMP_W'(64);
    localparam logic [CLAMP_W-1:0]        MAX_FWD_RESET  = CLAMP_W'(64);

    typedef enum logic [1:0] {
        REG_BOUND    = 2'd0,
        REG_MIN      = 2'd1,
        REG_MAX_BACK = 2'd2,
        REG_MAX_FWD  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [BOUND_W-1:0]        bound_frac;
        logic [INTENSITY_BITS-1:0] absolute_min_intensity;
        logic [CLAMP_W-1:0]        max_back_peaks;
        logic [CLAMP_W-1:0]        max_forward_peaks;
    } t_cfg;

    typedef struct packed {
        logic                      en;
        logic [ADDR_W-1:0]         addr;
        logic [INTENSITY_BITS-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } t_rd_req;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RDREF = 5'b00010,
        S_INIT  = 5'b00100,
        S_READ  = 5'b01000,
        S_STEP  = 5'b10000
    } t_state;

endpackage

FILE: rtl/eib_regs.sv
// ---------------------------------------------------------------------------
// eib_regs
// configuration register file behind the apb-style port
// ---------------------------------------------------------------------------
module eib_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eib_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [eib_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [eib_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output eib_pkg::t_cfg                    o_cfg
);

    eib_pkg::t_cfg    r_cfg;
    eib_pkg::t_cfg    n_cfg;
    eib_pkg::t_reg_idx idx;
    logic             wr;

    assign idx    = eib_pkg::t_reg_idx'(paddr[3:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                eib_pkg::REG_BOUND:
                    n_cfg.bound_frac = pwdata[eib_pkg::BOUND_W-1:0];
                eib_pkg::REG_MIN:
                    n_cfg.absolute_min_intensity = pwdata[eib_pkg::INTENSITY_BITS-1:0];
                eib_pkg::REG_MAX_BACK:
                    n_cfg.max_back_peaks = pwdata[eib_pkg::CLAMP_W-1:0];
                eib_pkg::REG_MAX_FWD:
                    n_cfg.max_forward_peaks = pwdata[eib_pkg::CLAMP_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            eib_pkg::REG_BOUND:    prdata = eib_pkg::CFG_DATA_W'(r_cfg.bound_frac);
            eib_pkg::REG_MIN:      prdata = eib_pkg::CFG_DATA_W'(r_cfg.absolute_min_intensity);
            eib_pkg::REG_MAX_BACK: prdata = eib_pkg::CFG_DATA_W'(r_cfg.max_back_peaks);
            eib_pkg::REG_MAX_FWD:  prdata = eib_pkg::CFG_DATA_W'(r_cfg.max_forward_peaks);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound_frac             <= eib_pkg::BOUND_RESET;
            r_cfg.absolute_min_intensity <= eib_pkg::MIN_RESET;
            r_cfg.max_back_peaks         <= eib_pkg::MAX_BACK_RESET;
            r_cfg.max_forward_peaks      <= eib_pkg::MAX_FWD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/eib_store.sv
// ---------------------------------------------------------------------------
// eib_store
// peak intensity memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
module eib_store (
    input  logic                                i_clk,
    input  eib_pkg::t_wr_req                    i_wr,
    input  eib_pkg::t_rd_req                    i_rd,
    output logic [eib_pkg::INTENSITY_BITS-1:0]  o_rd_a,
    output logic [eib_pkg::INTENSITY_BITS-1:0]  o_rd_b
);

    logic [eib_pkg::INTENSITY_BITS-1:0] r_mem [eib_pkg::MAX_PEAKS];
    logic [eib_pkg::INTENSITY_BITS-1:0] r_rd_a;
    logic [eib_pkg::INTENSITY_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd.addr_a];
        r_rd_b <= r_mem[i_rd.addr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

FILE: rtl/eib_walk.sv
// ---------------------------------------------------------------------------
// eib_walk
// loads peaks, keeps the total and walks outward from the reference peak
// ---------------------------------------------------------------------------
module eib_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [eib_pkg::INTENSITY_BITS-1:0]  i_peak_intensity,
    input  logic                                i_last_peak,
    input  logic [eib_pkg::REF_W-1:0]           i_reference_index,
    input  eib_pkg::t_cfg                       i_cfg,
    output eib_pkg::t_wr_req                    o_wr,
    output eib_pkg::t_rd_req                    o_rd,
    input  logic [eib_pkg::INTENSITY_BITS-1:0]  i_rd_a,
    input  logic [eib_pkg::INTENSITY_BITS-1:0]  i_rd_b,
    output logic                                o_result_valid,
    output logic [eib_pkg::CLAMP_W-1:0]         o_back_count,
    output logic [eib_pkg::CLAMP_W-1:0]         o_forward_count,
    output logic                                o_bad_reference
);

    eib_pkg::t_state                 r_state, n_state;
    logic [eib_pkg::CNT_W-1:0]       r_count, n_count;
    logic [eib_pkg::SUM_W-1:0]       r_total, n_total;
    logic                            r_valid, n_valid;

    logic [eib_pkg::ADDR_W-1:0]      r_ref;
    logic [eib_pkg::CNT_W-1:0]       r_back;
    logic [eib_pkg::CNT_W-1:0]       r_fwd;
    logic [eib_pkg::SUM_W-1:0]       r_sum;
    logic [eib_pkg::PROD_W-1:0]      r_prod;
    logic                            r_below;
    logic [eib_pkg::CLAMP_W-1:0]     r_back_out;
    logic [eib_pkg::CLAMP_W-1:0]     r_fwd_out;
    logic                            r_bad_out;

    logic                            accept;
    logic                            store_ok;
    logic [eib_pkg::CNT_W-1:0]       cnt_after;
    logic                            bad_ref;
    logic [eib_pkg::CNT_W-1:0]       fwd_pos;
    logic [eib_pkg::ADDR_W-1:0]      back_addr;
    logic                            back_done;
    logic                            fwd_done;
    logic [eib_pkg::INTENSITY_BITS-1:0] bi;
    logic [eib_pkg::INTENSITY_BITS-1:0] fi;
    logic                            stop;
    logic                            take_back;

    assign accept    = i_start & (r_state == eib_pkg::S_IDLE);
    assign o_busy    = (r_state != eib_pkg::S_IDLE);
    assign store_ok  = (r_count < eib_pkg::CNT_W'(eib_pkg::MAX_PEAKS));
    assign cnt_after = store_ok ? (r_count + eib_pkg::CNT_W'(1)) : r_count;
    assign bad_ref   = (eib_pkg::CNT_W'(i_reference_index) >= cnt_after);

    assign o_wr.en   = accept & store_ok;
    assign o_wr.addr = r_count[eib_pkg::ADDR_W-1:0];
    assign o_wr.data = i_peak_intensity;

    // neighbour positions derived from the reference and the counts taken
    assign fwd_pos   = eib_pkg::CNT_W'(r_ref) + r_fwd + eib_pkg::CNT_W'(1);
    assign back_addr = r_ref - r_back[eib_pkg::ADDR_W-1:0] - eib_pkg::ADDR_W'(1);
    assign back_done = (r_back == eib_pkg::CNT_W'(r_ref));
    assign fwd_done  = (fwd_pos >= r_count);

    assign o_rd.addr_a = (r_state == eib_pkg::S_RDREF) ? r_ref : back_addr;
    assign o_rd.addr_b = fwd_pos[eib_pkg::ADDR_W-1:0];

    assign bi = back_done ? '0 : i_rd_a;
    assign fi = fwd_done  ? '0 : i_rd_b;
    assign stop = !r_below || (back_done && fwd_done) ||
                  ((bi < i_cfg.absolute_min_intensity) &&
                   (fi < i_cfg.absolute_min_intensity));
    assign take_back = fwd_done || (!back_done && (bi > fi));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_total = r_total;
        n_valid = 1'b0;
        unique case (r_state)
            eib_pkg::S_IDLE: begin
                if (accept) begin
                    if (store_ok) begin
                        n_count = cnt_after;
                        n_total = r_total + eib_pkg::SUM_W'(i_peak_intensity);
                    end
                    if (i_last_peak) begin
                        if (bad_ref) begin
                            n_valid = 1'b1;
                            n_count = '0;
                            n_total = '0;
                        end else begin
                            n_state = eib_pkg::S_RDREF;
                        end
                    end
                end
            end
            eib_pkg::S_RDREF: n_state = eib_pkg::S_INIT;
            eib_pkg::S_INIT:  n_state = eib_pkg::S_READ;
            eib_pkg::S_READ:  n_state = eib_pkg::S_STEP;
            eib_pkg::S_STEP: begin
                if (stop) begin
                    n_state = eib_pkg::S_IDLE;
                    n_valid = 1'b1;
                    n_count = '0;
                    n_total = '0;
                end else begin
                    n_state = eib_pkg::S_READ;
                end
            end
            default: n_state = eib_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eib_pkg::S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            eib_pkg::S_IDLE: begin
                if (accept && i_last_peak) begin
                    r_ref  <= eib_pkg::ADDR_W'(i_reference_index);
                    r_back <= '0;
                    r_fwd  <= '0;
                    if (bad_ref) begin
                        r_back_out <= '0;
                        r_fwd_out  <= '0;
                        r_bad_out  <= 1'b1;
                    end
                end
            end
            eib_pkg::S_INIT: begin
                r_sum  <= eib_pkg::SUM_W'(i_rd_a);
                r_prod <= eib_pkg::PROD_W'(i_cfg.bound_frac) * eib_pkg::PROD_W'(r_total);
            end
            eib_pkg::S_READ: begin
                r_below <= (eib_pkg::PROD_W'({r_sum, eib_pkg::BOUND_SHIFT'(0)}) < r_prod);
            end
            eib_pkg::S_STEP: begin
                if (stop) begin
                    r_back_out <= (eib_pkg::CLAMP_W'(r_back) > i_cfg.max_back_peaks) ?
                                  i_cfg.max_back_peaks : eib_pkg::CLAMP_W'(r_back);
                    r_fwd_out  <= (eib_pkg::CLAMP_W'(r_fwd) > i_cfg.max_forward_peaks) ?
                                  i_cfg.max_forward_peaks : eib_pkg::CLAMP_W'(r_fwd);
                    r_bad_out  <= 1'b0;
                end else if (take_back) begin
                    r_sum  <= r_sum + eib_pkg::SUM_W'(bi);
                    r_back <= r_back + eib_pkg::CNT_W'(1);
                end else begin
                    r_sum <= r_sum + eib_pkg::SUM_W'(fi);
                    r_fwd <= r_fwd + eib_pkg::CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_result_valid  = r_valid;
    assign o_back_count    = r_back_out;
    assign o_forward_count = r_fwd_out;
    assign o_bad_reference = r_bad_out;

endmodule

FILE: rtl/envelope_intensity_bound_top.sv
// ---------------------------------------------------------------------------
// envelope_intensity_bound_top
// loads one isotopic envelope and reports how many peaks either side of
// the reference are needed to reach the configured share of its intensity
//
// channel   direction  handshake                    payload
// item      in         start & !busy                i_peak_intensity, i_last_peak,
//                                                    i_reference_index
// result    out        o_result_valid, one cycle    o_back_count, o_forward_count,
//                                                    o_bad_reference
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// a non-final peak word is accepted and busy stays low
// a final peak word keeps busy high through RDREF, INIT and one READ, STEP pair
// per peak added by the walk (up to 63) plus the last; each step is one read
// of both neighbours plus update; result strobes in the same cycle busy falls
// a bad reference returns its result the cycle after it is taken
// synchronous active-low reset clears peak count and total, config to defaults
// results are never held off; busy is the only stall on the item side
// ---------------------------------------------------------------------------
module envelope_intensity_bound_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [eib_pkg::INTENSITY_BITS-1:0]  i_peak_intensity,
    input  logic                                i_last_peak,
    input  logic [eib_pkg::REF_W-1:0]           i_reference_index,
    output logic                                o_result_valid,
    output logic [eib_pkg::CLAMP_W-1:0]         o_back_count,
    output logic [eib_pkg::CLAMP_W-1:0]         o_forward_count,
    output logic                                o_bad_reference,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [eib_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [eib_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [eib_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    eib_pkg::t_cfg                       cfg;
    eib_pkg::t_wr_req                    wr;
    eib_pkg::t_rd_req                    rd;
    logic [eib_pkg::INTENSITY_BITS-1:0]  rd_a;
    logic [eib_pkg::INTENSITY_BITS-1:0]  rd_b;

    eib_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    eib_store u_store (
        .i_clk  (i_clk),
        .i_wr   (wr),
        .i_rd   (rd),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    eib_walk u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_peak_intensity  (i_peak_intensity),
        .i_last_peak       (i_last_peak),
        .i_reference_index (i_reference_index),
        .i_cfg             (cfg),
        .o_wr              (wr),
        .o_rd              (rd),
        .i_rd_a            (rd_a),
        .i_rd_b            (rd_b),
        .o_result_valid    (o_result_valid),
        .o_back_count      (o_back_count),
        .o_forward_count   (o_forward_count),
        .o_bad_reference   (o_bad_reference)
    );

endmodule
